[hw/rtl/constant_pool_dedup_table_defines.svh]
// Assertion macros shared by the checker of the constant pool dedup table.
// Depends on nothing; the asserting file must provide clk and rst_n.
`ifndef CONSTANT_POOL_DEDUP_TABLE_DEFINES_SVH
`define CONSTANT_POOL_DEDUP_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CPDT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CPDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/cpdt_pkg.sv]
// Package for the constant pool dedup table: controller states, command and
// status structs, field widths and the constant compare and hash helpers.
`default_nettype none

package cpdt_pkg;

  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned OFFSET_W    = 11;
  localparam int unsigned SLOT_SHIFT  = 3;
  localparam int unsigned FOLD_W      = 16;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [VALUE_W-1:0] ABS_MASK     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] EXP_ALL_ONES = 64'h7FF0_0000_0000_0000;

  localparam logic KIND_INT    = 1'b0;
  localparam logic KIND_DOUBLE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_HEAD,
    ST_FETCH,
    ST_CMP,
    ST_INSERT,
    ST_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic load_in;
    logic calc_hash;
    logic read_head;
    logic fetch;
    logic compare;
    logic follow;
    logic hit;
    logic insert;
    logic publish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic fetch_ok;
    logic match;
    logic bkt_ok;
    logic next_valid;
    logic out_free;
  } sts_t;

  function automatic logic is_nan(input logic [VALUE_W-1:0] b);
    return (b & ABS_MASK) > EXP_ALL_ONES;
  endfunction

  // Integers compare bit for bit; doubles numerically (zeros equal, NaN never).
  function automatic logic same_constant(input logic kind,
                                         input logic [VALUE_W-1:0] a,
                                         input logic [VALUE_W-1:0] b);
    logic eq;
    eq = (a == b);
    if (kind == KIND_INT) begin
      return eq;
    end
    if (is_nan(a) || is_nan(b)) begin
      return 1'b0;
    end
    if (((a & ABS_MASK) == '0) && ((b & ABS_MASK) == '0)) begin
      return 1'b1;
    end
    return eq;
  endfunction

  // Folds a constant to 16 bits; both double zeros fold to the same word.
  function automatic logic [FOLD_W-1:0] fold_key(input logic kind,
                                                 input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] c;
    c = v;
    if ((kind == KIND_DOUBLE) && ((v & ABS_MASK) == '0)) begin
      c = '0;
    end
    return c[15:0] ^ c[31:16] ^ c[47:32] ^ c[63:48] ^ {15'd0, kind};
  endfunction

endpackage

`default_nettype wire

[hw/rtl/cpdt_ctrl.sv]
// Controller state machine of the constant pool dedup table.
// Depends on cpdt_pkg for the state type and the command and status structs.
`default_nettype none

module cpdt_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  cpdt_pkg::sts_t    sts,
  output cpdt_pkg::cmd_t    cmd
);

  cpdt_pkg::state_t state_r;
  cpdt_pkg::state_t state_nxt;

  // State register; reset starts the bucket head clearing pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cpdt_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: hash, read the bucket head, then walk the chain.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cpdt_pkg::ST_CLEAR: begin
        if (sts.clear_done) state_nxt = cpdt_pkg::ST_IDLE;
      end
      cpdt_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = cpdt_pkg::ST_HASH;
      end
      cpdt_pkg::ST_HASH:  state_nxt = cpdt_pkg::ST_HEAD;
      cpdt_pkg::ST_HEAD:  state_nxt = cpdt_pkg::ST_FETCH;
      cpdt_pkg::ST_FETCH: begin
        state_nxt = sts.fetch_ok ? cpdt_pkg::ST_CMP : cpdt_pkg::ST_INSERT;
      end
      cpdt_pkg::ST_CMP: begin
        if (sts.match) begin
          state_nxt = cpdt_pkg::ST_RESULT;
        end else if (sts.bkt_ok && sts.next_valid) begin
          state_nxt = cpdt_pkg::ST_FETCH;
        end else begin
          state_nxt = cpdt_pkg::ST_INSERT;
        end
      end
      cpdt_pkg::ST_INSERT: state_nxt = cpdt_pkg::ST_RESULT;
      cpdt_pkg::ST_RESULT: begin
        if (sts.out_free) state_nxt = cpdt_pkg::ST_IDLE;
      end
      default: state_nxt = cpdt_pkg::ST_IDLE;
    endcase
  end

  // Outputs: datapath commands and the input ready.
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      cpdt_pkg::ST_CLEAR: cmd.clear = 1'b1;
      cpdt_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      cpdt_pkg::ST_HASH:  cmd.calc_hash = 1'b1;
      cpdt_pkg::ST_HEAD:  cmd.read_head = 1'b1;
      cpdt_pkg::ST_FETCH: cmd.fetch     = 1'b1;
      cpdt_pkg::ST_CMP: begin
        cmd.compare = 1'b1;
        cmd.hit     = sts.match;
        cmd.follow  = !sts.match && sts.bkt_ok && sts.next_valid;
      end
      cpdt_pkg::ST_INSERT: cmd.insert  = 1'b1;
      cpdt_pkg::ST_RESULT: cmd.publish = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/cpdt_datapath.sv]
// Datapath of the constant pool dedup table: bucket head memory, entry memory
// with chain links, compare logic, entry counter and output register.
// Depends on cpdt_pkg.
`default_nettype none

module cpdt_datapath #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned BUCKETS = 64
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_kind,
  input  wire  [cpdt_pkg::VALUE_W-1:0]          in_value,
  input  cpdt_pkg::cmd_t                        cmd,
  output cpdt_pkg::sts_t                        sts,
  input  wire                                   out_tready,
  output logic                                  out_tvalid,
  output logic [cpdt_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  localparam int unsigned PW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW    = $clog2(ENTRIES + 1);
  localparam int unsigned BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned PROD_W = cpdt_pkg::FOLD_W + 13;

  // Entry store: value, kind, owning bucket and link to the next entry.
  logic [cpdt_pkg::VALUE_W-1:0] ent_val_mem [ENTRIES];
  logic                         ent_kind_mem[ENTRIES];
  logic [BW-1:0]                ent_bkt_mem [ENTRIES];
  logic [PW-1:0]                ent_nxt_mem [ENTRIES];
  logic                         ent_nv_mem  [ENTRIES];
  // Bucket heads: newest entry of each bucket.
  logic [PW-1:0]                head_mem    [BUCKETS];

  logic [cpdt_pkg::VALUE_W-1:0] val_r;
  logic                         kind_r;
  logic [cpdt_pkg::FOLD_W-1:0]  fold_r;
  logic [BW-1:0]                bucket_r;
  logic [BW-1:0]                clr_addr_r;
  logic [PW-1:0]                head_rd_r;
  logic                         first_r;
  logic                         head_ok_r;
  logic [PW-1:0]                ptr_r;
  logic [PW-1:0]                next_ptr_r;
  logic [CW-1:0]                count_r;
  logic [cpdt_pkg::VALUE_W-1:0] ent_val_r;
  logic                         ent_kind_r;
  logic [BW-1:0]                ent_bkt_r;
  logic [PW-1:0]                ent_nxt_r;
  logic                         ent_nv_r;
  logic [cpdt_pkg::OFFSET_W-1:0] res_offset_r;
  logic                         res_present_r;
  logic                         res_full_r;
  logic                         out_valid_r;
  logic [cpdt_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic [PROD_W-1:0]            prod;
  logic [PW-1:0]                fetch_ptr;
  logic                         table_full;

  assign prod       = PROD_W'(fold_r) * PROD_W'(BUCKETS);
  assign fetch_ptr  = first_r ? head_rd_r : next_ptr_r;
  assign table_full = (count_r == CW'(ENTRIES));

  // Status back to the controller.
  always_comb begin
    sts.clear_done = (clr_addr_r == BW'(BUCKETS - 1));
    sts.fetch_ok   = (CW'(fetch_ptr) < count_r);
    sts.bkt_ok     = (ent_bkt_r == bucket_r);
    sts.match      = sts.bkt_ok && (ent_kind_r == kind_r) &&
                     cpdt_pkg::same_constant(kind_r, ent_val_r, val_r);
    sts.next_valid = ent_nv_r;
    sts.out_free   = !out_valid_r || out_tready;
  end

  // Input capture, hashing and chain walk registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      val_r  <= in_value;
      kind_r <= in_kind;
      fold_r <= cpdt_pkg::fold_key(in_kind, in_value);
    end
    if (cmd.calc_hash) begin
      bucket_r <= prod[cpdt_pkg::FOLD_W +: BW];
    end
    if (cmd.read_head) begin
      head_rd_r <= head_mem[bucket_r];
      first_r   <= 1'b1;
      head_ok_r <= 1'b0;
    end
    if (cmd.fetch) begin
      ptr_r      <= fetch_ptr;
      ent_val_r  <= ent_val_mem[fetch_ptr];
      ent_kind_r <= ent_kind_mem[fetch_ptr];
      ent_bkt_r  <= ent_bkt_mem[fetch_ptr];
      ent_nxt_r  <= ent_nxt_mem[fetch_ptr];
      ent_nv_r   <= ent_nv_mem[fetch_ptr];
    end
    // A head is only trusted if it lies below the count and names this bucket.
    if (cmd.compare && first_r && sts.bkt_ok) begin
      head_ok_r <= 1'b1;
    end
    if (cmd.follow) begin
      next_ptr_r <= ent_nxt_r;
      first_r    <= 1'b0;
    end
  end

  // Clearing address: walks every bucket head once after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear) begin
      clr_addr_r <= clr_addr_r + BW'(1);
    end
  end

  // Head clearing after reset, and entry and head memory writes on insertion.
  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      head_mem[clr_addr_r] <= '0;
    end else if (cmd.insert && !table_full) begin
      head_mem[bucket_r] <= count_r[PW-1:0];
    end
    if (cmd.insert && !table_full) begin
      ent_val_mem [count_r[PW-1:0]] <= val_r;
      ent_kind_mem[count_r[PW-1:0]] <= kind_r;
      ent_bkt_mem [count_r[PW-1:0]] <= bucket_r;
      ent_nxt_mem [count_r[PW-1:0]] <= head_rd_r;
      ent_nv_mem  [count_r[PW-1:0]] <= head_ok_r;
    end
  end

  // Entry counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.insert && !table_full) begin
      count_r <= count_r + CW'(1);
    end
  end

  // Result held until the output register is free.
  always_ff @(posedge clk) begin
    if (cmd.hit) begin
      res_offset_r  <= cpdt_pkg::OFFSET_W'(32'(ptr_r) << cpdt_pkg::SLOT_SHIFT);
      res_present_r <= 1'b1;
      res_full_r    <= 1'b0;
    end else if (cmd.insert) begin
      res_offset_r  <= table_full ? '0 :
                       cpdt_pkg::OFFSET_W'(32'(count_r) << cpdt_pkg::SLOT_SHIFT);
      res_present_r <= 1'b0;
      res_full_r    <= table_full;
    end
  end

  // Output register: a transfer completes when valid and ready are both high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.publish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      out_data_r <= {3'b000, res_full_r, res_present_r, res_offset_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

[hw/rtl/constant_pool_dedup_table.sv]
// Sequence: after the input transfer the constant is hashed, its bucket head is read
// and its chain walked entry by entry; a miss inserts it unless the table is full,
// and the result is then offered. A new constant is taken only once the previous
// result is in the output register, so a stalled result holds input off after one
// further constant. Reset (rst_n, synchronous, active low) empties the table, then
// a clearing pass over the bucket heads runs before the first input transfer.
`default_nettype none

module constant_pool_dedup_table #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned BUCKETS = 64
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [63:0] in_tdata,   // [63:0] value_bits
  input  wire         in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata   // [10:0] slot_offset, [11] was_present,
                                  // [12] table_full, [15:13] zero
);

  cpdt_pkg::cmd_t cmd;
  cpdt_pkg::sts_t sts;

  // Sequencing of one lookup or insertion.
  cpdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Memories, compare and result registers.
  cpdt_datapath #(
    .ENTRIES (ENTRIES),
    .BUCKETS (BUCKETS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_kind    (in_tuser),
    .in_value   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

[hw/rtl/cpdt_checker.sv]
// Port-level checker for the constant pool dedup table, bound to the top level.
// Depends on constant_pool_dedup_table_defines.svh for the assertion macros.
`default_nettype none
`include "constant_pool_dedup_table_defines.svh"

module cpdt_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [15:0] out_tdata
);

  // A stalled result keeps its data.
  `CPDT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result changed while stalled")

  // A hit never reports a full table as well.
  `CPDT_ASSERT_NOW(a_hit_not_full, out_tvalid, !(out_tdata[11] && out_tdata[12]), "hit and full both set")

  // A full report carries a zero offset, every offset is slot aligned and the top bits are zero.
  `CPDT_ASSERT_NOW(a_offset_form, out_tvalid, (out_tdata[2:0] == 3'd0) && (out_tdata[15:13] == 3'd0) && (!out_tdata[12] || (out_tdata[10:0] == 11'd0)), "malformed result word")

  // The block is busy in the cycle after taking a constant.
  `CPDT_ASSERT_NEXT(a_busy_after_in, in_tvalid && in_tready, !in_tready, "input ready again at once")

endmodule

bind constant_pool_dedup_table cpdt_checker u_cpdt_checker (.*);

`default_nettype wire
